// ===== rtl/ppbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the packed pixel board store.
package ppbs_pkg;

   localparam int BOARD_SIDE_DEFAULT = 8;
   localparam int CELL_DEPTH         = 64;
   localparam int ADDR_W             = 6;
   localparam int COORD_W            = 3;
   localparam int COLOUR_W           = 3;
   localparam int CMD_W              = 3;

   localparam logic [COLOUR_W-1:0] LIT_COLOUR = 3'd7;

   localparam logic [CMD_W-1:0] CMD_READ         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_COLOUR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_LIT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DECAY        = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [COLOUR_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] colour;
      logic                lit;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECAY_RD,
      ST_DECAY_WR,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic decay_rd;
      logic decay_wr;
      logic walk_clr;
      logic load_rsp;
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic req_decay;
      logic walk_last;
      logic rsp_free;
   } stat_type;

endpackage

// ===== rtl/ppbs_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the packed pixel board store.
module ppbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ppbs_pkg::stat_type  stat,
   output ppbs_pkg::ctl_type   ctl
);

   ppbs_pkg::state_type state_ff;
   ppbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppbs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_decay ? ppbs_pkg::ST_DECAY_RD : ppbs_pkg::ST_FINISH;
            end
         end
         ppbs_pkg::ST_DECAY_RD: begin
            state_in = ppbs_pkg::ST_DECAY_WR;
         end
         ppbs_pkg::ST_DECAY_WR: begin
            state_in = stat.walk_last ? ppbs_pkg::ST_FINISH : ppbs_pkg::ST_DECAY_RD;
         end
         ppbs_pkg::ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = ppbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl          = '0;
      case (state_ff)
         ppbs_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
         end
         ppbs_pkg::ST_DECAY_RD: begin
            ctl.decay_rd = 1'b1;
         end
         ppbs_pkg::ST_DECAY_WR: begin
            ctl.decay_wr = 1'b1;
            ctl.walk_clr = stat.walk_last;
         end
         ppbs_pkg::ST_FINISH: begin
            ctl.load_rsp = stat.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_decay_starts_walk: assert property (@(posedge clock) disable iff (reset)
      ctl.accept && stat.req_decay |=> state_ff == ppbs_pkg::ST_DECAY_RD)
      else $error("decay beat did not start the board walk");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      state_ff == ppbs_pkg::ST_DECAY_WR && !stat.walk_last
      |=> state_ff == ppbs_pkg::ST_DECAY_RD)
      else $error("board walk stopped early");

   a_finish_returns: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |=> state_ff == ppbs_pkg::ST_IDLE)
      else $error("result loaded but controller did not return to idle");

endmodule

// ===== rtl/ppbs_datapath.sv =====
`timescale 1ns / 1ps
// Cell memory, walk counter and result register of the packed pixel board store.
module ppbs_datapath #(
   parameter int BOARD_SIDE = ppbs_pkg::BOARD_SIDE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ppbs_pkg::req_type   req_data,
   input  ppbs_pkg::ctl_type   ctl,
   output ppbs_pkg::stat_type  stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppbs_pkg::rsp_type   rsp_data
);

   localparam int AW = ppbs_pkg::ADDR_W;
   localparam int CW = ppbs_pkg::COLOUR_W;
   localparam logic [AW-1:0] WALK_LAST = AW'(BOARD_SIDE * BOARD_SIDE - 1);
   localparam logic [ppbs_pkg::COORD_W:0] SIDE_C = (ppbs_pkg::COORD_W+1)'(BOARD_SIDE);

   logic [CW-1:0] cells_mem [ppbs_pkg::CELL_DEPTH];
   logic [ppbs_pkg::CELL_DEPTH-1:0] valid_ff;
   logic [ppbs_pkg::CELL_DEPTH-1:0] valid_in;
   logic [CW-1:0] rd_data_ff;
   logic          rd_valid_ff;
   logic [CW-1:0] rd_colour;

   logic [AW-1:0] walk_ff;
   logic [AW-1:0] walk_in;
   logic [ppbs_pkg::CMD_W-1:0] cmd_ff;
   logic          onboard_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   ppbs_pkg::rsp_type rsp_ff;
   ppbs_pkg::rsp_type rsp_in;

   logic [AW-1:0] req_idx;
   logic          req_onboard;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   assign req_idx     = AW'(req_data.col) + AW'(req_data.row) * AW'(BOARD_SIDE);
   assign req_onboard = ({1'b0, req_data.col} < SIDE_C) && ({1'b0, req_data.row} < SIDE_C);
   assign rd_colour   = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_idx;
      wr_data = req_data.value;
      if (ctl.accept && req_onboard) begin
         if (req_data.command == ppbs_pkg::CMD_WRITE_COLOUR) begin
            wr_en = 1'b1;
         end else if (req_data.command == ppbs_pkg::CMD_WRITE_LIT) begin
            wr_en   = 1'b1;
            wr_data = (req_data.value != '0) ? ppbs_pkg::LIT_COLOUR : '0;
         end
      end
      if (ctl.decay_wr) begin
         wr_en   = 1'b1;
         wr_addr = walk_ff;
         wr_data = (rd_colour != '0) ? rd_colour - CW'(1) : '0;
      end
   end

   assign rd_en   = ctl.accept || ctl.decay_rd;
   assign rd_addr = ctl.accept ? req_idx : walk_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= cells_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.accept && req_data.command == ppbs_pkg::CMD_CLEAR) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (ctl.walk_clr) begin
         walk_in = '0;
      end else if (ctl.decay_wr) begin
         walk_in = walk_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_in.colour = (cmd_ff == ppbs_pkg::CMD_READ && onboard_ff) ? rd_colour : '0;
      rsp_in.lit    = (rsp_in.colour == ppbs_pkg::LIT_COLOUR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff     <= req_data.command;
         onboard_ff <= req_onboard;
      end
      if (ctl.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.req_decay = (req_data.command == ppbs_pkg::CMD_DECAY);
   assign stat.walk_last = (walk_ff == WALK_LAST);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("result register loaded over an untaken beat");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.accept && req_data.command == ppbs_pkg::CMD_CLEAR |=> valid_ff == '0)
      else $error("clear left written cells behind");

   a_lit_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.lit == (rsp_ff.colour == ppbs_pkg::LIT_COLOUR))
      else $error("lit flag disagrees with colour");

endmodule

// ===== rtl/packed_pixel_board_store.sv =====
`timescale 1ns / 1ps
// Top level of the packed pixel board store: controller and datapath.
//
//   channel  direction  ports                              meaning
//   req      in         req_valid req_ready req_data       one command beat
//   rsp      out        rsp_valid rsp_ready rsp_data       one result beat per command
//
// Read, write colour, write lit, clear and unknown commands go from the accept state,
// which reads or writes the cell memory, to a finish state that loads the result.
// Decay walks the board in between: each cell needs a registered read, then a write.
// Reset and clear empty every cell at once through per-cell valid bits.
// A waiting result does not block acceptance of the next command; only loading
// the following result stalls until the waiting beat is taken.
module packed_pixel_board_store #(
   parameter int BOARD_SIDE = ppbs_pkg::BOARD_SIDE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ppbs_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ppbs_pkg::rsp_type  rsp_data
);

   // Commands from the controller, status back from the datapath
   ppbs_pkg::ctl_type  ctl;
   ppbs_pkg::stat_type stat;

   // Sequence each command: accept, walk the board for decay, load the result
   ppbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Hold the cells, the walk position and the result register
   ppbs_datapath #(
      .BOARD_SIDE (BOARD_SIDE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/ppbs_board_tb_pkg.sv =====
`timescale 1ns / 1ps
// Shadow board and result checker for the packed pixel board store testbench.
package ppbs_board_tb_pkg;
   import ppbs_pkg::*;

   localparam int SHADOW_SIDE = BOARD_SIDE_DEFAULT;

   class board_shadow;
      logic [COLOUR_W-1:0] colour_of [CELL_DEPTH];
      rsp_type             due_results [$];
      int                  mismatches;
      int                  checked;
      int                  per_command [8];

      function new();
         foreach (colour_of[i]) colour_of[i] = '0;
         foreach (per_command[i]) per_command[i] = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Map a coordinate pair to a cell; false when it lies off the board.
      function bit find_cell(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                             output int idx);
         idx = int'(c) + int'(r) * SHADOW_SIDE;
         return (int'(c) < SHADOW_SIDE) && (int'(r) < SHADOW_SIDE) && (idx < CELL_DEPTH);
      endfunction

      // Apply one accepted command to the shadow board and queue its result.
      function void note_command(input req_type beat);
         rsp_type res;
         int      idx;
         int      walk;
         res = '0;
         per_command[beat.command] += 1;
         case (beat.command)
            CMD_READ: begin
               if (find_cell(beat.col, beat.row, idx)) begin
                  res.colour = colour_of[idx];
                  res.lit    = (colour_of[idx] == LIT_COLOUR);
               end
            end
            CMD_WRITE_COLOUR: begin
               if (find_cell(beat.col, beat.row, idx)) colour_of[idx] = beat.value;
            end
            CMD_WRITE_LIT: begin
               if (find_cell(beat.col, beat.row, idx))
                  colour_of[idx] = (beat.value != '0) ? LIT_COLOUR : '0;
            end
            CMD_CLEAR: begin
               foreach (colour_of[i]) colour_of[i] = '0;
            end
            CMD_DECAY: begin
               walk = SHADOW_SIDE * SHADOW_SIDE;
               if (walk > CELL_DEPTH) walk = CELL_DEPTH;
               for (int i = 0; i < walk; i++)
                  if (colour_of[i] != '0) colour_of[i] = colour_of[i] - 1'b1;
            end
            default: ;
         endcase
         due_results.push_back(res);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result beat with nothing expected: colour %0d lit %0d",
                   got.colour, got.lit);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (got.colour !== want.colour) begin
            $error("colour: expected %0d, got %0d", want.colour, got.colour);
            mismatches++;
         end
         if (got.lit !== want.lit) begin
            $error("lit: expected %0d, got %0d", want.lit, got.lit);
            mismatches++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void flag_leftover();
         if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/packed_pixel_board_store_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the packed pixel board store: directed and random commands.
module packed_pixel_board_store_test;
   import ppbs_pkg::*;
   import ppbs_board_tb_pkg::*;

   // Allow many times the slowest correct run, in which every beat is a decay walk
   // plus the longest gap and stall.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_BEATS  = 500;
   localparam int DRAIN_CYCLES  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // While set, both sides run flat out with no idle cycles.
   bit quiet_spell = 1'b0;
   int cycle_count = 0;

   board_shadow shadow = new();

   packed_pixel_board_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watch both channels at every edge. Check the result beat first: it always
   // belongs to a command accepted at an earlier edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) shadow.check_result(rsp_data);
         if (req_valid && req_ready) shadow.note_command(req_data);
      end
   end

   // Give up on a hung block.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[packed_pixel_board_store] ERROR");
      $finish;
   end

   // Result side: stall a random number of cycles before taking each beat.
   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_spell ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic req_type compose_beat(input logic [CMD_W-1:0] cmd,
                                            input int c, input int r, input int v);
      req_type b;
      b.command = cmd;
      b.col     = c[COORD_W-1:0];
      b.row     = r[COORD_W-1:0];
      b.value   = v[COLOUR_W-1:0];
      return b;
   endfunction

   // Mostly cell traffic, with the odd whole-board walk, clear and unknown code.
   function automatic req_type random_beat();
      int          pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 35)      cmd = CMD_READ;
      else if (pick < 63) cmd = CMD_WRITE_COLOUR;
      else if (pick < 80) cmd = CMD_WRITE_LIT;
      else if (pick < 88) cmd = CMD_DECAY;
      else if (pick < 92) cmd = CMD_CLEAR;
      else                cmd = CMD_W'($urandom_range(5, 7));
      return compose_beat(cmd, $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 7));
   endfunction

   // Present one command beat after a random gap and hold it until taken.
   // Valid is left high on return; a gap in the next call or a hold-off drops it.
   task automatic send_command(input req_type beat);
      int gap;
      gap = quiet_spell ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every queued result has come back.
   task automatic wait_results_home();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: board corners, full and empty colours, lit writes,
      // decay down to and past zero, unknown codes, clear.
      send_command(compose_beat(CMD_READ,         0, 0, 0));  // cleared by reset
      send_command(compose_beat(CMD_READ,         7, 7, 7));
      send_command(compose_beat(CMD_WRITE_COLOUR, 7, 7, 7));
      send_command(compose_beat(CMD_READ,         7, 7, 0));  // lit
      send_command(compose_beat(CMD_WRITE_COLOUR, 0, 0, 1));
      send_command(compose_beat(CMD_WRITE_COLOUR, 7, 0, 3));
      send_command(compose_beat(CMD_WRITE_LIT,    0, 7, 5));  // nonzero flag stores 7
      send_command(compose_beat(CMD_READ,         0, 7, 0));
      send_command(compose_beat(CMD_DECAY,        0, 0, 0));
      send_command(compose_beat(CMD_READ,         7, 7, 0));  // 7 falls to 6
      send_command(compose_beat(CMD_READ,         0, 0, 0));
      send_command(compose_beat(CMD_READ,         7, 0, 0));
      send_command(compose_beat(CMD_DECAY,        7, 7, 7));
      send_command(compose_beat(CMD_READ,         0, 0, 0));  // zero stays zero
      send_command(compose_beat(CMD_WRITE_LIT,    0, 7, 0));  // zero flag stores 0
      send_command(compose_beat(CMD_READ,         0, 7, 0));
      send_command(compose_beat(3'd5,             7, 7, 7));  // unknown codes: no effect
      send_command(compose_beat(3'd6,             7, 7, 7));
      send_command(compose_beat(3'd7,             0, 0, 0));
      send_command(compose_beat(CMD_READ,         7, 7, 0));
      send_command(compose_beat(CMD_CLEAR,        7, 7, 7));
      send_command(compose_beat(CMD_READ,         7, 7, 0));
      send_command(compose_beat(CMD_WRITE_COLOUR, 3, 4, 7));
      send_command(compose_beat(CMD_READ,         3, 4, 0));
      send_command(compose_beat(CMD_WRITE_LIT,    7, 7, 7));

      // Hold the sender until the directed results are all home.
      wait_results_home();

      // Random part; one stretch runs with no idling on either side, and the
      // sender holds off once more at beat 300.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         quiet_spell = (n >= 150) && (n < 230);
         if (n == 300) wait_results_home();
         send_command(random_beat());
      end
      quiet_spell = 1'b0;

      wait_results_home();
      repeat (DRAIN_CYCLES) @(posedge clock);
      shadow.flag_leftover();

      $display("Run covered %0d commands with %0d results checked.",
               shadow.checked + shadow.pending(), shadow.checked);
      $display("Reads %0d, colour writes %0d, lit writes %0d, clears %0d, decays %0d, unknown %0d.",
               shadow.per_command[CMD_READ], shadow.per_command[CMD_WRITE_COLOUR],
               shadow.per_command[CMD_WRITE_LIT], shadow.per_command[CMD_CLEAR],
               shadow.per_command[CMD_DECAY],
               shadow.per_command[5] + shadow.per_command[6] + shadow.per_command[7]);
      if (shadow.mismatches == 0) begin
         $display("[packed_pixel_board_store] OK");
      end else begin
         $display("[packed_pixel_board_store] ERROR");
      end
      $finish;
   end

endmodule
